// ----- rtl/core/sctr_pkg.sv -----
// shared types, constants and round function for the speck-128/128 ctr block
package sctr_pkg;

  // configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 2;

  // register indexes, one 64-bit register every 8 bytes
  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_LOW  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NONCE_HIGH = 2'd3;

  // cipher word and block geometry
  localparam int WORD_W      = 64;
  localparam int COUNT_W     = 5;
  localparam int BLOCK_BYTES = 16;
  localparam int WORD_BYTES  = 8;
  localparam int ROT_HI      = 8;
  localparam int ROT_LO      = 3;

  typedef struct packed {
    logic [WORD_W-1:0] key_low;
    logic [WORD_W-1:0] key_high;
    logic [WORD_W-1:0] nonce_low;
    logic [WORD_W-1:0] nonce_high;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } pair_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXPAND,
    S_ENC,
    S_FINISH
  } state_t;

  // one speck round: x = (ror(x,8) + y) ^ k, y = rol(y,3) ^ x
  function automatic pair_t speck_round(input logic [WORD_W-1:0] hi,
                                        input logic [WORD_W-1:0] lo,
                                        input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] a;
    pair_t             res;
    a      = ({hi[ROT_HI-1:0], hi[WORD_W-1:ROT_HI]} + lo) ^ k;
    res.hi = a;
    res.lo = {lo[WORD_W-ROT_LO-1:0], lo[WORD_W-1:WORD_W-ROT_LO]} ^ a;
    return res;
  endfunction

  // keep the low n bytes of a word, n from 0 to 8
  function automatic logic [WORD_W-1:0] byte_mask(input logic [3:0] n);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_BYTES; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/sctr_ram.sv -----
// generic single-write, single-read ram with registered read data
module sctr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sctr_regs.sv -----
// apb register file holding key and nonce
module sctr_regs import sctr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_KEY_LOW:    cfg.key_low    <= pwdata;
        REG_KEY_HIGH:   cfg.key_high   <= pwdata;
        REG_NONCE_LOW:  cfg.nonce_low  <= pwdata;
        REG_NONCE_HIGH: cfg.nonce_high <= pwdata;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_KEY_LOW:    prdata = cfg.key_low;
      REG_KEY_HIGH:   prdata = cfg.key_high;
      REG_NONCE_LOW:  prdata = cfg.nonce_low;
      REG_NONCE_HIGH: prdata = cfg.nonce_high;
    endcase
  end

endmodule

// ----- rtl/core/sctr_core.sv -----
// round engine: input buffer, key expansion, ctr encryption, output register
module sctr_core import sctr_pkg::*; #(
  parameter int ROUND_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WORD_W-1:0]  data_low,
  input  logic [WORD_W-1:0]  data_high,
  input  logic [COUNT_W-1:0] byte_count,
  input  logic               start_of_message,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  result_low,
  output logic [WORD_W-1:0]  result_high
);

  localparam int RW = $clog2(ROUND_COUNT);
  localparam logic [RW-1:0] LAST_RND = RW'(ROUND_COUNT - 1);

  state_t state, state_next;

  // one-word input buffer
  logic               buf_valid;
  logic [WORD_W-1:0]  buf_low;
  logic [WORD_W-1:0]  buf_high;
  logic [COUNT_W-1:0] buf_count;
  logic               buf_som;

  // working set of the word in flight
  logic [WORD_W-1:0]  x;
  logic [WORD_W-1:0]  y;
  logic [RW-1:0]      rnd;
  logic [WORD_W-1:0]  work_low;
  logic [WORD_W-1:0]  work_high;
  logic [COUNT_W-1:0] work_count;
  logic [WORD_W-1:0]  counter;

  // round key memory ports
  logic               ram_we;
  logic [RW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               take;
  logic               out_free;
  logic               fin_fire;
  logic               last;
  pair_t              exp_rnd;
  pair_t              enc_rnd;
  logic [COUNT_W-1:0] buf_count_sat;
  logic [3:0]         lo_bytes;
  logic [3:0]         hi_bytes;

  sctr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUND_COUNT)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rnd),
    .wdata (y),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || !out_stall;
  assign last     = (rnd == LAST_RND);
  assign in_stall = buf_valid && !take;

  // round datapath for schedule and cipher
  assign exp_rnd = speck_round(x, y, WORD_W'(rnd));
  assign enc_rnd = speck_round(x, y, ram_rdata);

  // byte count above sixteen counts as a full block
  assign buf_count_sat = (buf_count > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES) : buf_count;
  assign lo_bytes = (work_count >= COUNT_W'(WORD_BYTES)) ? 4'(WORD_BYTES) : work_count[3:0];
  assign hi_bytes = (work_count > COUNT_W'(WORD_BYTES)) ?
                    4'(work_count - COUNT_W'(WORD_BYTES)) : 4'd0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (buf_valid) state_next = buf_som ? S_EXPAND : S_ENC;
      S_EXPAND: if (last) state_next = S_ENC;
      S_ENC:    if (last) state_next = S_FINISH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take      = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = '0;
    fin_fire  = 1'b0;
    unique case (state)
      S_IDLE:   take = buf_valid;
      S_EXPAND: ram_we = 1'b1;
      S_ENC:    ram_raddr = last ? '0 : rnd + 1'b1;
      S_FINISH: fin_fire = out_free;
      default:  ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      buf_valid <= 1'b0;
      out_valid <= 1'b0;
      counter   <= '0;
      rnd       <= '0;
    end else begin
      state <= state_next;
      if (in_valid && !in_stall) begin
        buf_valid <= 1'b1;
      end else if (take) begin
        buf_valid <= 1'b0;
      end
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // counter loads at message start, steps after a full block
      if (take && buf_som) begin
        counter <= cfg.nonce_low;
      end else if (fin_fire && work_count[4]) begin
        counter <= counter + 1'b1;
      end
      if (take || (state == S_EXPAND && last)) begin
        rnd <= '0;
      end else if (state == S_EXPAND || state == S_ENC) begin
        rnd <= rnd + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      buf_low   <= data_low;
      buf_high  <= data_high;
      buf_count <= byte_count;
      buf_som   <= start_of_message;
    end
    if (take) begin
      work_low   <= buf_low;
      work_high  <= buf_high;
      work_count <= buf_count_sat;
      if (buf_som) begin
        x <= cfg.key_high;
        y <= cfg.key_low;
      end else begin
        x <= cfg.nonce_high;
        y <= counter;
      end
    end else if (state == S_EXPAND) begin
      if (last) begin
        x <= cfg.nonce_high;
        y <= counter;
      end else begin
        x <= exp_rnd.hi;
        y <= exp_rnd.lo;
      end
    end else if (state == S_ENC) begin
      x <= enc_rnd.hi;
      y <= enc_rnd.lo;
    end
    if (fin_fire) begin
      result_low  <= (work_low ^ y) & byte_mask(lo_bytes);
      result_high <= (work_high ^ x) & byte_mask(hi_bytes);
    end
  end

endmodule

// ----- rtl/core/speck128_128_ctr_stream_xor.sv -----
// speck-128/128 counter mode stream xor, top level
// Each word is a 16-byte block that is xored with the Speck-128/128 encryption of
// (nonce_high, block counter); bytes past byte_count come out zero and the counter
// steps only after a full block. A word passes through load, one round per cycle
// on the single round unit, and handoff to the output register; a start-of-message
// word first runs the key schedule, which writes one round key per cycle into the
// round-key memory that the cipher rounds then read back through its one read port.
// One word waits in an input buffer while another is in the rounds, and a finished
// result waits in the output register while the next word runs its rounds; that
// word's handoff to the output register waits until the register is free. There is
// no clearing pass after reset; key, nonce and counter registers reset to zero.
module speck128_128_ctr_stream_xor import sctr_pkg::*; #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_W-1:0]     data_low,
  input  logic [WORD_W-1:0]     data_high,
  input  logic [COUNT_W-1:0]    byte_count,
  input  logic                  start_of_message,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_W-1:0]     result_low,
  output logic [WORD_W-1:0]     result_high
);

  cfg_t cfg;

  // configuration registers
  sctr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // cipher engine
  sctr_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_low         (data_low),
    .data_high        (data_high),
    .byte_count       (byte_count),
    .start_of_message (start_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_low       (result_low),
    .result_high      (result_high)
  );

endmodule

// ----- rtl/core/sctr_checker.sv -----
// port-level checks for the speck ctr block, bound to the top level
module sctr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] result_low,
  input logic [63:0] result_high
);

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // one buffer slot plus the round engine: at most two words taken in a row
  assert property (@(posedge clk) disable iff (rst)
    ((in_valid && !in_stall) ##1 (in_valid && !in_stall)) |=> in_stall)
    else $error("input accepted with buffer and engine both busy");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(result_low) && $stable(result_high)))
    else $error("stalled output word changed or dropped");

endmodule

bind speck128_128_ctr_stream_xor sctr_checker u_sctr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_low  (result_low),
  .result_high (result_high)
);

// ----- tb/tb_speck128_128_ctr_stream_xor.sv -----
// testbench for the speck-128/128 counter mode stream xor block
`timescale 1ns / 100ps

module tb_speck128_128_ctr_stream_xor;
  import sctr_pkg::*;

  localparam int ROUNDS       = 32;
  localparam int RANDOM_ITEMS = 650;
  localparam int LIMIT_CYCLES = 800000;
  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] ZERO = {WORD_W{1'b0}};
  localparam logic [COUNT_W-1:0] FULL = COUNT_W'(BLOCK_BYTES);

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [WORD_W-1:0]     data_low = '0;
  logic [WORD_W-1:0]     data_high = '0;
  logic [COUNT_W-1:0]    byte_count = '0;
  logic                  start_of_message = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WORD_W-1:0]     result_low;
  logic [WORD_W-1:0]     result_high;

  speck128_128_ctr_stream_xor #(.ROUND_COUNT(ROUNDS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_low(data_low), .data_high(data_high),
    .byte_count(byte_count), .start_of_message(start_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_low(result_low), .result_high(result_high)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // shadow of the configuration, counter and key schedule
  logic [WORD_W-1:0] cfg_shadow [4] = '{ZERO, ZERO, ZERO, ZERO};
  logic [WORD_W-1:0] ctr_shadow = ZERO;
  logic [WORD_W-1:0] rk_shadow [ROUNDS];

  // results still owed by the block, oldest first
  pair_t pending_results [$];

  // typed-in expectation that rides along with the word being driven
  logic              cur_chk = 1'b0;
  logic [WORD_W-1:0] cur_e_lo = ZERO;
  logic [WORD_W-1:0] cur_e_hi = ZERO;

  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;

  // one cipher round on (x, y)
  function automatic pair_t cipher_round(input pair_t s, input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] a;
    pair_t             t;
    a    = ({s.hi[7:0], s.hi[WORD_W-1:8]} + s.lo) ^ k;
    t.hi = a;
    t.lo = {s.lo[WORD_W-4:0], s.lo[WORD_W-1:WORD_W-3]} ^ a;
    return t;
  endfunction

  // low n bytes kept, n clipped to 0..8
  function automatic logic [WORD_W-1:0] keep_bytes(input int n);
    if (n >= WORD_BYTES) return ONES;
    if (n <= 0) return ZERO;
    return (64'h1 << (8 * n)) - 64'h1;
  endfunction

  // keystream xor for one accepted word, advancing the shadow state
  function automatic pair_t ctr_xor_predict(input logic [WORD_W-1:0] d_lo,
                                            input logic [WORD_W-1:0] d_hi,
                                            input logic [COUNT_W-1:0] cnt,
                                            input logic som);
    pair_t sch;
    pair_t ks;
    pair_t res;
    int    n;
    if (som) begin
      sch.hi = cfg_shadow[REG_KEY_HIGH];
      sch.lo = cfg_shadow[REG_KEY_LOW];
      for (int r = 0; r < ROUNDS; r++) begin
        rk_shadow[r] = sch.lo;
        sch = cipher_round(sch, WORD_W'(r));
      end
      ctr_shadow = cfg_shadow[REG_NONCE_LOW];
    end
    n = (cnt > FULL) ? BLOCK_BYTES : int'(cnt);
    ks.hi = cfg_shadow[REG_NONCE_HIGH];
    ks.lo = ctr_shadow;
    for (int r = 0; r < ROUNDS; r++) ks = cipher_round(ks, rk_shadow[r]);
    res.lo = (d_lo ^ ks.lo) & keep_bytes(n);
    res.hi = (d_hi ^ ks.hi) & keep_bytes(n - WORD_BYTES);
    if (n == BLOCK_BYTES) ctr_shadow = ctr_shadow + 64'h1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return ZERO;
      1: return ONES;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // cycle limit and switching between calm and busy stretches
  always @(posedge clk) begin
    cycles++;
    if (cycles % 256 == 0) calm = ($urandom_range(0, 3) == 0);
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_speck128_128_ctr_stream_xor: errors");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    int n;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      n = gap_len();
      if (n > 0) begin
        stall_left = n - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // accepted words feed the predictor, accepted results are checked
  always @(posedge clk) begin
    pair_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", result_low, ZERO);
        end else begin
          want = pending_results.pop_front();
          if (result_low !== want.lo) report_mismatch("result_low", result_low, want.lo);
          if (result_high !== want.hi) report_mismatch("result_high", result_high, want.hi);
        end
      end
      if (in_valid && !in_stall) begin
        want = ctr_xor_predict(data_low, data_high, byte_count, start_of_message);
        if (cur_chk) begin
          want.lo = cur_e_lo;
          want.hi = cur_e_hi;
        end
        pending_results.push_back(want);
      end
    end
  end

  // drive one word and wait for it to be taken
  task automatic send_word(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                           input logic [COUNT_W-1:0] cnt, input logic som,
                           input logic chk, input logic [WORD_W-1:0] e_lo,
                           input logic [WORD_W-1:0] e_hi);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    data_low         <= lo;
    data_high        <= hi;
    byte_count       <= cnt;
    start_of_message <= som;
    cur_chk          <= chk;
    cur_e_lo         <= e_lo;
    cur_e_hi         <= e_hi;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait for every owed result
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write followed by a read back
  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_shadow[idx] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== cfg_shadow[idx]) report_mismatch("register read", prdata, cfg_shadow[idx]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // directed plan: register writes and words, typed expectation where obvious
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [REG_IDX_W-1:0]  ridx;
    logic [WORD_W-1:0]     a;
    logic [WORD_W-1:0]     b;
    logic [COUNT_W-1:0]    cnt;
    logic                  som;
    logic                  chk;
    logic [WORD_W-1:0]     e_lo;
    logic [WORD_W-1:0]     e_hi;
  } row_t;

  localparam int PLAN_LEN = 33;

  row_t plan [PLAN_LEN] = '{
    // published speck-128/128 vector as key and nonce
    '{ROW_CFG,  REG_KEY_LOW,    64'h0706050403020100, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_CFG,  REG_KEY_HIGH,   64'h0f0e0d0c0b0a0908, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_CFG,  REG_NONCE_LOW,  64'h7469206564616d20, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_CFG,  REG_NONCE_HIGH, 64'h6c61766975716520, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b1, 1'b1,
      64'h7860fedf5c570d18, 64'ha65d985179783265},
    // byte count edges
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, FULL,  1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, 5'd0,  1'b0, 1'b1, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, 5'd1,  1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, 5'd8,  1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, 5'd9,  1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, 5'd15, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 5'd17,
      1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, 5'd31, 1'b0, 1'b0, ZERO, ZERO},
    // restart reloads the counter
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b1, 1'b1,
      64'h7860fedf5c570d18, 64'ha65d985179783265},
    // counter wrap with no carry into the high word
    '{ROW_CFG,  REG_NONCE_LOW,  64'hfffffffffffffffe, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_CFG,  REG_NONCE_HIGH, ONES, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b1, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b0, 1'b0, ZERO, ZERO},
    // key change inside a message waits for the next start
    '{ROW_CFG,  REG_KEY_LOW,  ONES, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_CFG,  REG_KEY_HIGH, ONES, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, 64'h8000000000000000, 64'h0000000000000001, FULL,
      1'b0, 1'b0, ZERO, ZERO},
    // high nonce word is used live
    '{ROW_CFG,  REG_NONCE_HIGH, ZERO, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, 64'h0123456789abcdef, 64'hfedcba9876543210, FULL,
      1'b0, 1'b0, ZERO, ZERO},
    // start word with nothing valid, then back-to-back starts
    '{ROW_WORD, REG_KEY_LOW, ONES, ONES, 5'd0, 1'b1, 1'b1, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b1, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b1, 1'b0, ZERO, ZERO},
    // all-zero key and nonce
    '{ROW_CFG,  REG_KEY_LOW,   ZERO, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_CFG,  REG_KEY_HIGH,  ZERO, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_CFG,  REG_NONCE_LOW, ZERO, ZERO, 5'd0, 1'b0, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, ZERO, ZERO, FULL, 1'b1, 1'b0, ZERO, ZERO},
    '{ROW_WORD, REG_KEY_LOW, 64'h7fffffffffffffff, 64'h8000000000000000, 5'd12,
      1'b0, 1'b0, ZERO, ZERO}
  };

  // stimulus
  initial begin
    row_t             row;
    int               done_items;
    int               msg_len;
    logic             cont;
    logic             som;
    logic [COUNT_W-1:0] cnt;
    done_items = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed plan
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        drain_pipe();
        cfg_write(row.ridx, row.a);
      end else begin
        send_word(row.a, row.b, row.cnt, row.som, row.chk, row.e_lo, row.e_hi);
      end
    end

    // random messages, some continuing across register changes
    while (done_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_pipe();
        if ($urandom_range(0, 1)) cfg_write(REG_KEY_LOW, pick_word());
        if ($urandom_range(0, 1)) cfg_write(REG_KEY_HIGH, pick_word());
        if ($urandom_range(0, 1)) cfg_write(REG_NONCE_LOW, pick_word());
        if ($urandom_range(0, 1)) cfg_write(REG_NONCE_HIGH, pick_word());
      end
      cont    = ($urandom_range(0, 5) == 0);
      msg_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      for (int i = 0; i < msg_len; i++) begin
        som = (i == 0 && !cont) || ($urandom_range(0, 39) == 0);
        cnt = FULL;
        if (i == msg_len - 1 && $urandom_range(0, 1)) cnt = COUNT_W'($urandom_range(1, 15));
        if ($urandom_range(0, 14) == 0) cnt = COUNT_W'($urandom_range(0, 31));
        send_word(pick_word(), pick_word(), cnt, som, 1'b0, ZERO, ZERO);
        done_items++;
      end
    end

    drain_pipe();
    repeat (2 * ROUNDS + 8) @(negedge clk);
    if (errors == 0) begin
      $display("tb_speck128_128_ctr_stream_xor: clean");
    end else begin
      $display("tb_speck128_128_ctr_stream_xor: errors");
    end
    $finish;
  end

endmodule
